>>> rtl/tcw_pkg.sv
// Shared constants and controller/datapath interface types for the text console writer.
package tcw_pkg;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int TAB_WIDTH    = 8;
  localparam int CELL_COUNT   = SCREEN_COLS * SCREEN_ROWS;
  localparam int SCROLL_LIMIT = CELL_COUNT - SCREEN_COLS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0700;
  localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h07;

  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic exec;
    logic scroll_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic need_scroll;
  } dp_status_t;

endpackage

>>> rtl/text_console_writer.sv
// Top level of the 80x25 text console writer.
// Flow: an accepted transaction passes through an execute state, a scroll state when a put
// scrolls, and a done state that waits for the output slot; only one is in flight at a time. A
// scroll moves every row up through the screen store's one read and one write port and blanks the bottom row.
// Reset: cursor to 0,0 and attribute to 0x07, then a clearing pass of the screen store
// with in_ready low; cfg writes are taken during it.
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_cursor_offset,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attr,
  output logic        out_scrolled
);
  import tcw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_operation      (in_operation),
    .in_char_code      (in_char_code),
    .in_cell_index     (in_cell_index),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_offset (out_cursor_offset),
    .out_read_char     (out_read_char),
    .out_read_attr     (out_read_attr),
    .out_scrolled      (out_scrolled)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scrolled) |-> (out_cursor_row == 5'(SCREEN_ROWS - 1)))
    else $error("scroll reported with cursor off the bottom row");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_col < 7'(SCREEN_COLS) && out_cursor_row < 5'(SCREEN_ROWS)))
    else $error("cursor outside the screen");

  a_scroll_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scrolled) |-> (out_read_char == 8'd0 && out_read_attr == 8'd0))
    else $error("read data on a scrolling put");

  a_scroll_engine: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scroll_step && !status.cnt_last) |=> cmd.scroll_step)
    else $error("scroll copy stopped early");
`endif

endmodule

>>> rtl/tcw_ctrl.sv
// Sequencing state machine for the text console writer.
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tcw_pkg::dp_status_t status,
  output tcw_pkg::ctrl_cmd_t  cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.need_scroll ? S_SCROLL : S_DONE;
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (status.cnt_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the output slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/tcw_datapath.sv
// Screen store, cursor registers, attribute register and result registers.
module tcw_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tcw_pkg::ctrl_cmd_t  cmd,
  output tcw_pkg::dp_status_t status,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_operation,
  input  logic [7:0]          in_char_code,
  input  logic [10:0]         in_cell_index,
  output logic [6:0]          out_cursor_col,
  output logic [4:0]          out_cursor_row,
  output logic [10:0]         out_cursor_offset,
  output logic [7:0]          out_read_char,
  output logic [7:0]          out_read_attr,
  output logic                out_scrolled
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] mem_q_r;

  logic [ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] cnt_r;

  logic              op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [ADDR_W-1:0] idx_r;
  logic              rd_ok_r;
  logic              scroll_flag_r;

  logic              wr_pend_r;
  logic              wr_blank_r;
  logic [ADDR_W-1:0] wr_addr_r;

  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [ADDR_W-1:0] out_off_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [ATTR_W-1:0] out_attr_r;
  logic              out_scr_r;

  logic [COL_W:0]    col_inc, tab_col;
  logic              row_adv;
  logic [ROW_W:0]    row_sum;
  logic              need_scroll;
  logic [ADDR_W-1:0] cell_pos;
  logic              put_exec;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // next cursor for a put
  always_comb begin
    col_inc = {1'b0, col_r} + (COL_W+1)'(1);
    tab_col = {1'b0, col_r & ~COL_W'(TAB_WIDTH - 1)} + (COL_W+1)'(TAB_WIDTH);
    col_nxt = col_r;
    row_adv = 1'b0;
    case (ch_r)
      CH_LF: begin
        col_nxt = '0;
        row_adv = 1'b1;
      end
      CH_TAB: begin
        if (tab_col >= (COL_W+1)'(SCREEN_COLS)) begin
          col_nxt = '0;
          row_adv = 1'b1;
        end else begin
          col_nxt = tab_col[COL_W-1:0];
        end
      end
      CH_CR: col_nxt = '0;
      default: begin
        if (col_inc >= (COL_W+1)'(SCREEN_COLS)) begin
          col_nxt = '0;
          row_adv = 1'b1;
        end else begin
          col_nxt = col_inc[COL_W-1:0];
        end
      end
    endcase
    row_sum     = {1'b0, row_r} + {{ROW_W{1'b0}}, row_adv};
    need_scroll = (op_r == OP_PUT) && (row_sum > (ROW_W+1)'(SCREEN_ROWS - 1));
    row_nxt     = need_scroll ? ROW_W'(SCREEN_ROWS - 1) : row_sum[ROW_W-1:0];
  end

  assign cell_pos = ADDR_W'(row_r) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col_r);
  assign put_exec = cmd.exec && (op_r == OP_PUT);

  assign status.need_scroll = need_scroll;
  assign status.cnt_last    = (cnt_r == ADDR_W'(CELL_COUNT - 1));

  // one write port: clearing pass, printed char, or pending scroll copy
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = BLANK_CELL;
    if (cmd.clear_step) begin
      wr_en = 1'b1;
    end else if (wr_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = wr_addr_r;
      wr_data = wr_blank_r ? BLANK_CELL : mem_q_r;
    end else if (put_exec && ch_r != CH_LF && ch_r != CH_TAB && ch_r != CH_CR) begin
      wr_en   = 1'b1;
      wr_addr = cell_pos;
      wr_data = {attr_r, ch_r};
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r;
    if (cmd.exec && op_r == OP_READ) begin
      rd_en = rd_ok_r;
    end else if (cmd.scroll_step && cnt_r < ADDR_W'(SCROLL_LIMIT)) begin
      rd_en   = 1'b1;
      rd_addr = cnt_r + ADDR_W'(SCREEN_COLS);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r    <= ATTR_DEFAULT;
      col_r     <= '0;
      row_r     <= '0;
      cnt_r     <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      if (cfg_we) attr_r <= cfg_wdata;
      if (put_exec) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (cmd.exec) cnt_r <= '0;
      else if (cmd.clear_step || cmd.scroll_step) cnt_r <= cnt_r + ADDR_W'(1);
      // copy write follows its read in the next cycle
      wr_pend_r <= cmd.scroll_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      ch_r    <= in_char_code;
      idx_r   <= in_cell_index;
      rd_ok_r <= (in_cell_index < ADDR_W'(CELL_COUNT));
    end
    if (cmd.exec) scroll_flag_r <= need_scroll;
    if (cmd.scroll_step) begin
      wr_addr_r  <= cnt_r;
      wr_blank_r <= (cnt_r >= ADDR_W'(SCROLL_LIMIT));
    end
    if (cmd.load_out) begin
      out_col_r <= col_r;
      out_row_r <= row_r;
      out_off_r <= cell_pos;
      out_scr_r <= (op_r == OP_PUT) && scroll_flag_r;
      if (op_r == OP_READ && rd_ok_r) begin
        out_char_r <= mem_q_r[CHAR_W-1:0];
        out_attr_r <= mem_q_r[CELL_W-1:CHAR_W];
      end else begin
        out_char_r <= '0;
        out_attr_r <= '0;
      end
    end
  end

  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_offset = out_off_r;
  assign out_read_char     = out_char_r;
  assign out_read_attr     = out_attr_r;
  assign out_scrolled      = out_scr_r;

endmodule
